[hdl/gwcc_pkg.sv]
package gwcc_pkg;

  // Configuration register indexes
  localparam logic [1:0] CFG_CELL_SIZE = 2'd0;
  localparam logic [1:0] CFG_WALL_HALF = 2'd1;
  localparam logic [1:0] CFG_EDGE_EPS  = 2'd2;

  // Command codes
  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  // Wall codes, equal to the bit position in a wall entry
  localparam logic [1:0] WALL_POS_X = 2'd0;
  localparam logic [1:0] WALL_NEG_X = 2'd1;
  localparam logic [1:0] WALL_POS_Z = 2'd2;
  localparam logic [1:0] WALL_NEG_Z = 2'd3;

  // Shared divider: 52-bit dividend, 26-bit divisor, one quotient bit a cycle
  localparam int DIV_DW = 52;
  localparam int DIV_RW = 26;
  // Square root: 52-bit radicand, 26-bit root, one root bit a cycle
  localparam int SQ_SW  = 52;
  localparam int SQ_RW  = 26;
  // Push accumulators
  localparam int SUM_W  = 36;

endpackage

[hdl/grid_wall_circle_collision.sv]
// Grid wall / circle collision engine.
//
// Input channel: raise start_i with the command fields while busy_o is low;
// the transaction is taken at that clock edge. A load (cmd_i = 0) writes the
// four wall bits of one cell into the wall memory in that same edge and gives
// no result; the next command may follow at once. A query (cmd_i = 1) raises
// busy_o until its result is out.
// Result channel: done_o is high for exactly one cycle with is_colliding_o,
// push_x_o and push_z_o. The receiver cannot stall; it must take the result.
// Query steps: two serial divisions find the centre cell; each of the 9
// neighbor cells is then visited, and an in-grid cell has its four walls
// checked in turn, a present wall being tested against the circle's reach.
// A wall that touches the circle takes a square root and, unless the centre
// lies inside it, two divisions more. The serial divider and square root set
// how long a query holds busy_o.
// Configuration: cfg_ready_o is always high; write only while busy_o is low.
// Reset: registers take their reset values and the wall memory is cleared one
// entry a cycle, with busy_o high meanwhile.
module grid_wall_circle_collision
  import gwcc_pkg::*;
#(
  parameter int GRID_WIDTH = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic               cmd_i,
  input  logic [3:0]         cell_x_i,
  input  logic [3:0]         cell_z_i,
  input  logic [3:0]         wall_bits_i,
  input  logic signed [31:0] centre_x_i,
  input  logic signed [31:0] centre_z_i,
  input  logic [23:0]        circle_radius_i,
  output logic               done_o,
  output logic               is_colliding_o,
  output logic signed [31:0] push_x_o,
  output logic signed [31:0] push_z_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [1:0]         cfg_index_i,
  input  logic [23:0]        cfg_data_i
);

  localparam int IW    = (GRID_WIDTH > 1) ? $clog2(GRID_WIDTH) : 1;
  localparam int DEPTH = GRID_WIDTH * GRID_WIDTH;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = IW + 3;   // signed cell coordinate, holds +-(GRID_WIDTH+2)
  localparam int PW    = IW + 38;  // signed doubled world position

  localparam logic [4:0] S_CLEAR = 5'd0;
  localparam logic [4:0] S_IDLE  = 5'd1;
  localparam logic [4:0] S_DIV   = 5'd2;
  localparam logic [4:0] S_DIVX  = 5'd3;
  localparam logic [4:0] S_DIVZ  = 5'd4;
  localparam logic [4:0] S_CELL  = 5'd5;
  localparam logic [4:0] S_WALL  = 5'd6;
  localparam logic [4:0] S_CLAMP = 5'd7;
  localparam logic [4:0] S_CHECK = 5'd8;
  localparam logic [4:0] S_SQSUM = 5'd9;
  localparam logic [4:0] S_SQRT  = 5'd10;
  localparam logic [4:0] S_MULX  = 5'd11;
  localparam logic [4:0] S_ACCX  = 5'd12;
  localparam logic [4:0] S_ACCZ  = 5'd13;
  localparam logic [4:0] S_NEXT  = 5'd14;
  localparam logic [4:0] S_DONE  = 5'd15;

  // Configuration registers
  logic [23:0] cell_size_q;
  logic [22:0] wall_half_q;
  logic [15:0] edge_eps_q;
  logic [23:0] cs_eff;

  assign cfg_ready_o = 1'b1;
  assign cs_eff      = (cell_size_q == 24'd0) ? 24'd1 : cell_size_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_size_q <= 24'd262144;
      wall_half_q <= 23'd6554;
      edge_eps_q  <= 16'd1;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_CELL_SIZE: cell_size_q <= cfg_data_i;
        CFG_WALL_HALF: wall_half_q <= cfg_data_i[22:0];
        CFG_EDGE_EPS:  edge_eps_q  <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // Control and datapath registers
  logic [4:0]              state_q, ret_q;
  logic [AW-1:0]           clr_cnt_q;
  logic signed [PW-1:0]    px_q, pz_q;
  logic [24:0]             r2_q;
  logic [49:0]             r2sq_q;
  logic signed [PW-1:0]    p_q, w_q, g_q;
  logic signed [CW-1:0]    ix_q, iz_q;
  logic [1:0]              nx_q, nz_q, wall_q;
  logic signed [PW-1:0]    offx_q, offz_q;
  logic signed [PW-1:0]    lox_q, hix_q, loz_q, hiz_q;
  logic signed [PW-1:0]    dx_q, dz_q;
  logic [SQ_SW-1:0]        dx2_q, dz2_q;
  logic                    hit_q;
  logic signed [SUM_W-1:0] sx_q, sz_q;

  logic [DIV_DW-1:0]       div_quo_q;
  logic [DIV_RW-1:0]       div_rem_q, div_den_q;
  logic [5:0]              div_cnt_q;
  logic                    div_neg_q;

  logic [SQ_SW-1:0]        sq_rad_q;
  logic [SQ_RW+1:0]        sq_rem_q;
  logic [SQ_RW-1:0]        sq_root_q;
  logic [4:0]              sq_cnt_q;

  assign busy_o = (state_q != S_IDLE);

  // Neighbor cell under visit
  logic signed [CW-1:0] gx_s, gz_s;
  logic                 cell_in_grid, cell_even;
  logic [IW-1:0]        gx_idx, gz_idx;
  logic [24+IW:0]       offx_raw, offz_raw;

  assign gx_s = ix_q + $signed({{(CW-2){1'b0}}, nx_q}) - CW'(1);
  assign gz_s = iz_q + $signed({{(CW-2){1'b0}}, nz_q}) - CW'(1);
  assign cell_in_grid = !gx_s[CW-1] && ($unsigned(gx_s) < CW'(GRID_WIDTH)) &&
                        !gz_s[CW-1] && ($unsigned(gz_s) < CW'(GRID_WIDTH));
  assign cell_even = ~(gx_s[0] ^ gz_s[0]);
  assign gx_idx    = gx_s[IW-1:0];
  assign gz_idx    = gz_s[IW-1:0];
  assign offx_raw  = {cs_eff, 1'b0} * gx_idx;
  assign offz_raw  = {cs_eff, 1'b0} * gz_idx;

  // Wall memory: one write port, one registered read port
  logic [3:0]    wall_mem [DEPTH];
  logic [3:0]    rd_bits_q;
  logic [AW-1:0] rd_addr, wr_addr;
  logic          wr_en;
  logic [3:0]    wr_data;
  logic          load_take, load_in_grid;

  assign load_in_grid = (32'(cell_x_i) < GRID_WIDTH) && (32'(cell_z_i) < GRID_WIDTH);
  assign load_take    = (state_q == S_IDLE) && start_i && (cmd_i == CMD_LOAD);
  assign rd_addr      = AW'(32'(gz_idx) * GRID_WIDTH + 32'(gx_idx));

  always_comb begin
    if (state_q == S_CLEAR) begin
      wr_en   = 1'b1;
      wr_addr = clr_cnt_q;
      wr_data = 4'd0;
    end else begin
      wr_en   = load_take && load_in_grid;
      wr_addr = AW'(32'(cell_z_i) * GRID_WIDTH + 32'(cell_x_i));
      wr_data = wall_bits_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      wall_mem[wr_addr] <= wr_data;
    end
    rd_bits_q <= wall_mem[rd_addr];
  end

  // Divider step: restoring, one quotient bit a cycle
  logic [DIV_RW:0]   div_sh, div_sub;
  logic              div_ge;
  assign div_sh  = {div_rem_q, div_quo_q[DIV_DW-1]};
  assign div_ge  = div_sh >= {1'b0, div_den_q};
  assign div_sub = div_sh - {1'b0, div_den_q};

  // Square root step: one root bit a cycle
  logic [SQ_RW+3:0] sq_sh, sq_trial, sq_sub;
  logic             sq_ge;
  assign sq_sh    = {sq_rem_q, sq_rad_q[SQ_SW-1:SQ_SW-2]};
  assign sq_trial = {2'b00, sq_root_q, 2'b01};
  assign sq_ge    = sq_sh >= sq_trial;
  assign sq_sub   = sq_sh - sq_trial;

  // Dividends for the x cell index (at query start) and the z cell index
  logic signed [PW-1:0] cs_s, px_in, pz_in, numx, numz;
  logic [PW-1:0]        magx, magz;
  assign cs_s  = $signed({{(PW-24){1'b0}}, cs_eff});
  assign px_in = $signed({{(PW-33){centre_x_i[31]}}, centre_x_i, 1'b0});
  assign pz_in = $signed({{(PW-33){centre_z_i[31]}}, centre_z_i, 1'b0});
  assign numx  = px_in + cs_s;
  assign numz  = pz_q + cs_s;
  assign magx  = numx[PW-1] ? $unsigned(-numx) : $unsigned(numx);
  assign magz  = numz[PW-1] ? $unsigned(-numz) : $unsigned(numz);

  // Clamp into the current box
  logic signed [PW-1:0] clx_lo, clx, clz_lo, clz;
  assign clx_lo = (px_q < lox_q) ? lox_q : px_q;
  assign clx    = (clx_lo > hix_q) ? hix_q : clx_lo;
  assign clz_lo = (pz_q < loz_q) ? loz_q : pz_q;
  assign clz    = (clz_lo > hiz_q) ? hiz_q : clz_lo;

  // Contribution operands
  logic signed [PW-1:0] r2_s;
  logic signed [PW-1:0] dx_abs, dz_abs;
  logic [24:0]          span;
  logic [49:0]          dx_sq, dz_sq, mul_x, mul_z;
  logic signed [SUM_W-1:0] contrib;
  assign r2_s    = $signed({{(PW-25){1'b0}}, r2_q});
  assign dx_abs  = dx_q[PW-1] ? -dx_q : dx_q;
  assign dz_abs  = dz_q[PW-1] ? -dz_q : dz_q;
  assign span    = 25'({1'b0, r2_q} - sq_root_q);
  assign dx_sq   = dx_abs[24:0] * dx_abs[24:0];
  assign dz_sq   = dz_abs[24:0] * dz_abs[24:0];
  assign mul_x   = dx_abs[24:0] * span;
  assign mul_z   = dz_abs[24:0] * span;
  assign contrib = div_neg_q ? -$signed({{(SUM_W-26){1'b0}}, div_quo_q[25:0]})
                             :  $signed({{(SUM_W-26){1'b0}}, div_quo_q[25:0]});

  // Cell index from a quotient magnitude, magnitude held to at most GRID_WIDTH+1
  function automatic logic signed [CW-1:0] cell_of(input logic neg,
                                                   input logic [DIV_DW-1:0] mag);
    logic [DIV_DW-1:0] lim;
    logic [CW-1:0]     m;
    lim = DIV_DW'(GRID_WIDTH + 1);
    m   = (mag > lim) ? CW'(lim) : CW'(mag);
    return neg ? $signed(-m) : $signed(m);
  endfunction

  // Final halving toward zero and saturation
  function automatic logic signed [31:0] half_sat(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] h;
    h = (v + $signed({{(SUM_W-1){1'b0}}, v[SUM_W-1]})) >>> 1;
    if (h > $signed(SUM_W'(32'h7fffffff))) begin
      return 32'sh7fffffff;
    end else if (h < -$signed(SUM_W'(33'h80000000))) begin
      return 32'sh80000000;
    end
    return h[31:0];
  endfunction

  logic wall_last;
  assign wall_last = (wall_q == WALL_NEG_Z);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_CLEAR;
      ret_q     <= S_IDLE;
      clr_cnt_q <= '0;
      done_o    <= 1'b0;
      hit_q     <= 1'b0;
    end else begin
      done_o <= 1'b0;
      unique case (state_q)
        S_CLEAR: begin
          // Sweep the wall memory to zero
          clr_cnt_q <= clr_cnt_q + AW'(1);
          if (clr_cnt_q == AW'(DEPTH - 1)) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (start_i && (cmd_i == CMD_QUERY)) begin
            px_q      <= px_in;
            pz_q      <= pz_in;
            r2_q      <= {circle_radius_i, 1'b0};
            hit_q     <= 1'b0;
            sx_q      <= '0;
            sz_q      <= '0;
            div_quo_q <= magx[DIV_DW-1:0];
            div_neg_q <= numx[PW-1];
            div_rem_q <= '0;
            div_den_q <= DIV_RW'({cs_eff, 1'b0});
            div_cnt_q <= 6'(DIV_DW - 1);
            ret_q     <= S_DIVX;
            state_q   <= S_DIV;
          end
        end
        S_DIV: begin
          div_rem_q <= div_ge ? div_sub[DIV_RW-1:0] : div_sh[DIV_RW-1:0];
          div_quo_q <= {div_quo_q[DIV_DW-2:0], div_ge};
          div_cnt_q <= div_cnt_q - 6'd1;
          if (div_cnt_q == 6'd0) begin
            state_q <= ret_q;
          end
        end
        S_DIVX: begin
          // Hold the x cell, start the z division, set up the box extents
          ix_q      <= cell_of(div_neg_q, div_quo_q);
          r2sq_q    <= r2_q * r2_q;
          p_q       <= cs_s;
          w_q       <= cs_s - $signed({{(PW-24){1'b0}}, wall_half_q, 1'b0});
          g_q       <= cs_s + $signed({{(PW-24){1'b0}}, wall_half_q, 1'b0})
                            - $signed({{(PW-18){1'b0}}, edge_eps_q, 2'b00});
          div_quo_q <= magz[DIV_DW-1:0];
          div_neg_q <= numz[PW-1];
          div_rem_q <= '0;
          div_cnt_q <= 6'(DIV_DW - 1);
          ret_q     <= S_DIVZ;
          state_q   <= S_DIV;
        end
        S_DIVZ: begin
          iz_q    <= cell_of(div_neg_q, div_quo_q);
          nx_q    <= 2'd0;
          nz_q    <= 2'd0;
          state_q <= S_CELL;
        end
        S_CELL: begin
          // The memory read of this cell lands in rd_bits_q at this edge
          offx_q  <= $signed({{(PW-25-IW){1'b0}}, offx_raw}) +
                     (cell_even ? $signed({{(PW-17){1'b0}}, edge_eps_q, 1'b0}) : '0);
          offz_q  <= $signed({{(PW-25-IW){1'b0}}, offz_raw}) +
                     (cell_even ? $signed({{(PW-17){1'b0}}, edge_eps_q, 1'b0}) : '0);
          wall_q  <= WALL_POS_X;
          state_q <= cell_in_grid ? S_WALL : S_NEXT;
        end
        S_WALL: begin
          if (!rd_bits_q[wall_q]) begin
            wall_q  <= wall_q + 2'd1;
            state_q <= wall_last ? S_NEXT : S_WALL;
          end else begin
            case (wall_q)
              WALL_POS_X: begin
                lox_q <= offx_q + w_q;  hix_q <= offx_q + p_q;
                loz_q <= offz_q - g_q;  hiz_q <= offz_q + g_q;
              end
              WALL_NEG_X: begin
                lox_q <= offx_q - p_q;  hix_q <= offx_q - w_q;
                loz_q <= offz_q - g_q;  hiz_q <= offz_q + g_q;
              end
              WALL_POS_Z: begin
                lox_q <= offx_q - g_q;  hix_q <= offx_q + g_q;
                loz_q <= offz_q + w_q;  hiz_q <= offz_q + g_q;
              end
              default: begin
                lox_q <= offx_q - g_q;  hix_q <= offx_q + g_q;
                loz_q <= offz_q - g_q;  hiz_q <= offz_q - w_q;
              end
            endcase
            state_q <= S_CLAMP;
          end
        end
        S_CLAMP: begin
          dx_q    <= px_q - clx;
          dz_q    <= pz_q - clz;
          state_q <= S_CHECK;
        end
        S_CHECK: begin
          // Drop boxes beyond the radius on either axis
          dx2_q <= SQ_SW'(dx_sq);
          dz2_q <= SQ_SW'(dz_sq);
          if ((dx_abs > r2_s) || (dz_abs > r2_s)) begin
            wall_q  <= wall_q + 2'd1;
            state_q <= wall_last ? S_NEXT : S_WALL;
          end else begin
            state_q <= S_SQSUM;
          end
        end
        S_SQSUM: begin
          sq_rad_q  <= dx2_q + dz2_q;
          sq_rem_q  <= '0;
          sq_root_q <= '0;
          sq_cnt_q  <= 5'(SQ_RW - 1);
          if ((dx2_q + dz2_q) > SQ_SW'(r2sq_q)) begin
            wall_q  <= wall_q + 2'd1;
            state_q <= wall_last ? S_NEXT : S_WALL;
          end else begin
            hit_q   <= 1'b1;
            state_q <= S_SQRT;
          end
        end
        S_SQRT: begin
          sq_rem_q  <= sq_ge ? sq_sub[SQ_RW+1:0] : sq_sh[SQ_RW+1:0];
          sq_root_q <= {sq_root_q[SQ_RW-2:0], sq_ge};
          sq_rad_q  <= {sq_rad_q[SQ_SW-3:0], 2'b00};
          sq_cnt_q  <= sq_cnt_q - 5'd1;
          if (sq_cnt_q == 5'd0) begin
            state_q <= S_MULX;
          end
        end
        S_MULX: begin
          // Centre inside the box: zero push, flag already set
          if (sq_root_q == '0) begin
            wall_q  <= wall_q + 2'd1;
            state_q <= wall_last ? S_NEXT : S_WALL;
          end else begin
            div_quo_q <= DIV_DW'(mul_x);
            div_neg_q <= dx_q[PW-1];
            div_rem_q <= '0;
            div_den_q <= sq_root_q;
            div_cnt_q <= 6'(DIV_DW - 1);
            ret_q     <= S_ACCX;
            state_q   <= S_DIV;
          end
        end
        S_ACCX: begin
          sx_q      <= sx_q + contrib;
          div_quo_q <= DIV_DW'(mul_z);
          div_neg_q <= dz_q[PW-1];
          div_rem_q <= '0;
          div_cnt_q <= 6'(DIV_DW - 1);
          ret_q     <= S_ACCZ;
          state_q   <= S_DIV;
        end
        S_ACCZ: begin
          sz_q    <= sz_q + contrib;
          wall_q  <= wall_q + 2'd1;
          state_q <= wall_last ? S_NEXT : S_WALL;
        end
        S_NEXT: begin
          // Advance across the 3x3 neighborhood, row by row
          if (nx_q == 2'd2) begin
            nx_q <= 2'd0;
            if (nz_q == 2'd2) begin
              state_q <= S_DONE;
            end else begin
              nz_q    <= nz_q + 2'd1;
              state_q <= S_CELL;
            end
          end else begin
            nx_q    <= nx_q + 2'd1;
            state_q <= S_CELL;
          end
        end
        S_DONE: begin
          done_o         <= 1'b1;
          is_colliding_o <= hit_q;
          push_x_o       <= half_sat(sx_q);
          push_z_o       <= half_sat(sz_q);
          state_q        <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

[tb/grid_wall_circle_collision_checker.sv]
`timescale 1ns / 100ps

module grid_wall_circle_collision_checker
  import gwcc_pkg::*;
#(
  parameter int GRID_WIDTH = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic               busy_i,
  input  logic               cmd_i,
  input  logic [3:0]         cell_x_i,
  input  logic [3:0]         cell_z_i,
  input  logic [3:0]         wall_bits_i,
  input  logic signed [31:0] centre_x_i,
  input  logic signed [31:0] centre_z_i,
  input  logic [23:0]        circle_radius_i,
  input  logic               done_i,
  input  logic               is_colliding_i,
  input  logic signed [31:0] push_x_i,
  input  logic signed [31:0] push_z_i,
  input  logic               cfg_valid_i,
  input  logic               cfg_ready_i,
  input  logic [1:0]         cfg_index_i,
  input  logic [23:0]        cfg_data_i,
  output int                 fail_count_o,
  output int                 pending_o,
  output int                 hits_o
);

  typedef struct packed {
    logic               hit;
    logic signed [31:0] x;
    logic signed [31:0] z;
  } push_t;

  push_t       expected_push_q[$];
  logic [23:0] cell_size_q;
  logic [22:0] wall_half_q;
  logic [15:0] edge_eps_q;
  logic [3:0]  wall_map_q[GRID_WIDTH*GRID_WIDTH];

  function automatic longint unsigned root_floor(longint unsigned s);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > s) b = b >> 2;
    while (b != 0) begin
      if (s >= r + b) begin
        s = s - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic logic signed [31:0] sat32(longint signed v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic longint signed clamp(longint signed v, longint signed lo,
                                          longint signed hi);
    if (v < lo) v = lo;
    if (v > hi) v = hi;
    return v;
  endfunction

  // All geometry in doubled units so half a cell stays exact.
  function automatic push_t compute_push(logic signed [31:0] cx, logic signed [31:0] cz,
                                         logic [23:0] rad);
    longint signed cs, wh2, ep2, px, pz, r2, ix, iz, bp, bw, bg;
    longint signed offx, offz, dx, dz, s, q, sx, sz;
    longint signed lox[4], hix[4], loz[4], hiz[4];
    logic [3:0] bits;
    push_t res;
    cs = cell_size_q;
    if (cs == 0) cs = 1;
    wh2 = 2 * longint'(wall_half_q);
    ep2 = 2 * longint'(edge_eps_q);
    px = 2 * longint'(cx);
    pz = 2 * longint'(cz);
    r2 = 2 * longint'(rad);
    ix = (px + cs) / (2 * cs);
    iz = (pz + cs) / (2 * cs);
    bp = cs;
    bw = cs - wh2;
    bg = cs + wh2 - 2 * ep2;
    lox[WALL_POS_X] = bw;  hix[WALL_POS_X] = bp;  loz[WALL_POS_X] = -bg; hiz[WALL_POS_X] = bg;
    lox[WALL_NEG_X] = -bp; hix[WALL_NEG_X] = -bw; loz[WALL_NEG_X] = -bg; hiz[WALL_NEG_X] = bg;
    lox[WALL_POS_Z] = -bg; hix[WALL_POS_Z] = bg;  loz[WALL_POS_Z] = bw;  hiz[WALL_POS_Z] = bg;
    lox[WALL_NEG_Z] = -bg; hix[WALL_NEG_Z] = bg;  loz[WALL_NEG_Z] = -bg; hiz[WALL_NEG_Z] = -bw;
    res.hit = 1'b0;
    sx = 0;
    sz = 0;
    for (longint signed gz = iz - 1; gz <= iz + 1; gz++) begin
      for (longint signed gx = ix - 1; gx <= ix + 1; gx++) begin
        // skip neighbours that fall off the grid
        if (gz < 0 || gz >= GRID_WIDTH || gx < 0 || gx >= GRID_WIDTH) continue;
        bits = wall_map_q[gz * GRID_WIDTH + gx];
        offx = 2 * cs * gx;
        offz = 2 * cs * gz;
        if (((gx + gz) & 1) == 0) begin
          offx += ep2;
          offz += ep2;
        end
        for (int w = 0; w < 4; w++) begin
          if (!bits[w]) continue;
          dx = px - clamp(px, offx + lox[w], offx + hix[w]);
          dz = pz - clamp(pz, offz + loz[w], offz + hiz[w]);
          if (dx > r2 || dx < -r2 || dz > r2 || dz < -r2) continue;
          s = dx * dx + dz * dz;
          if (s > r2 * r2) continue;
          res.hit = 1'b1;
          q = root_floor(s);
          // centre inside the box: flag only, no push
          if (q > 0) begin
            sx += dx * (r2 - q) / q;
            sz += dz * (r2 - q) / q;
          end
        end
      end
    end
    res.x = sat32(sx / 2);
    res.z = sat32(sz / 2);
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    push_t got, exp_r;
    if (!rst_ni) begin
      cell_size_q  <= 24'd262144;
      wall_half_q  <= 23'd6554;
      edge_eps_q   <= 16'd1;
      fail_count_o <= 0;
      hits_o       <= 0;
      for (int i = 0; i < GRID_WIDTH * GRID_WIDTH; i++) wall_map_q[i] <= 4'd0;
      expected_push_q.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_CELL_SIZE: cell_size_q <= cfg_data_i;
          CFG_WALL_HALF: wall_half_q <= cfg_data_i[22:0];
          CFG_EDGE_EPS:  edge_eps_q  <= cfg_data_i[15:0];
          default: ;
        endcase
      end
      if (done_i) begin
        got = '{is_colliding_i, push_x_i, push_z_i};
        if (expected_push_q.size() == 0) begin
          $display("%0t: unexpected result hit=%0b x=%0d z=%0d", $time,
                   got.hit, got.x, got.z);
          fail_count_o <= fail_count_o + 1;
        end else begin
          exp_r = expected_push_q.pop_front();
          if (got !== exp_r) begin
            $display("%0t: mismatch expected hit=%0b x=%0d z=%0d actual hit=%0b x=%0d z=%0d",
                     $time, exp_r.hit, exp_r.x, exp_r.z, got.hit, got.x, got.z);
            fail_count_o <= fail_count_o + 1;
          end
          if (exp_r.hit) hits_o <= hits_o + 1;
        end
      end
      if (start_i && !busy_i) begin
        if (cmd_i == CMD_LOAD) begin
          if (cell_x_i < GRID_WIDTH && cell_z_i < GRID_WIDTH)
            wall_map_q[cell_z_i * GRID_WIDTH + cell_x_i] <= wall_bits_i;
        end else begin
          expected_push_q.push_back(compute_push(centre_x_i, centre_z_i, circle_radius_i));
        end
      end
    end
  end

  assign pending_o = expected_push_q.size();

endmodule

[tb/grid_wall_circle_collision_tb.sv]
`timescale 1ns / 100ps

module grid_wall_circle_collision_tb;
  import gwcc_pkg::*;

  localparam int GRID_WIDTH = 16;
  // index past the register list; the block must ignore it
  localparam logic [1:0] CFG_SPARE = 2'd3;
  localparam int ITEMS = 1350;
  localparam int CALM_ITEMS = 150;
  // a query runs serial divisions and square roots; allow generous headroom
  localparam int STALL_LIMIT = 40000;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               start_i = 1'b0;
  logic               busy_o;
  logic               cmd_i = CMD_LOAD;
  logic [3:0]         cell_x_i = '0;
  logic [3:0]         cell_z_i = '0;
  logic [3:0]         wall_bits_i = '0;
  logic signed [31:0] centre_x_i = '0;
  logic signed [31:0] centre_z_i = '0;
  logic [23:0]        circle_radius_i = '0;
  logic               done_o;
  logic               is_colliding_o;
  logic signed [31:0] push_x_o;
  logic signed [31:0] push_z_o;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [1:0]         cfg_index_i = CFG_CELL_SIZE;
  logic [23:0]        cfg_data_i = '0;

  int fail_count, pending, hits;
  int load_count, query_count, cfg_count, stall_cycles;
  logic [23:0] cur_cs;
  logic        allow_idle;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  grid_wall_circle_collision #(.GRID_WIDTH(GRID_WIDTH)) dut (.*);

  grid_wall_circle_collision_checker #(.GRID_WIDTH(GRID_WIDTH)) u_checker (
    .clk_i, .rst_ni, .start_i, .busy_i(busy_o), .cmd_i, .cell_x_i, .cell_z_i,
    .wall_bits_i, .centre_x_i, .centre_z_i, .circle_radius_i,
    .done_i(done_o), .is_colliding_i(is_colliding_o), .push_x_i(push_x_o),
    .push_z_i(push_z_o), .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_index_i,
    .cfg_data_i, .fail_count_o(fail_count), .pending_o(pending), .hits_o(hits)
  );

  // Watchdog: count cycles in which no transaction moves on any channel.
  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || done_o || (cfg_valid_i && cfg_ready_o) || !rst_ni) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("%0t: watchdog expired, nothing accepted for %0d cycles", $time, STALL_LIMIT);
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  // Hold start and the fields until the block takes the transaction.
  task automatic issue(logic cmd, logic [3:0] cx, logic [3:0] cz, logic [3:0] bits,
                       logic signed [31:0] px, logic signed [31:0] pz, logic [23:0] rad);
    start_i         <= 1'b1;
    cmd_i           <= cmd;
    cell_x_i        <= cx;
    cell_z_i        <= cz;
    wall_bits_i     <= bits;
    centre_x_i      <= px;
    centre_z_i      <= pz;
    circle_radius_i <= rad;
    do @(posedge clk_i); while (busy_o);
    if (cmd == CMD_LOAD) load_count++;
    else query_count++;
  endtask

  task automatic load_cell(logic [3:0] cx, logic [3:0] cz, logic [3:0] bits);
    issue(CMD_LOAD, cx, cz, bits, $urandom, $urandom, 24'($urandom));
  endtask

  task automatic query(logic signed [31:0] px, logic signed [31:0] pz, logic [23:0] rad);
    issue(CMD_QUERY, 4'($urandom), 4'($urandom), 4'($urandom), px, pz, rad);
  endtask

  // Drop start and wait until every result is back and the block is idle.
  task automatic drain();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0 || busy_o) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  // Write all registers back to back, plus the spare index; valid stays high.
  task automatic set_config(logic [23:0] cs, logic [23:0] wh, logic [23:0] ep);
    logic [1:0]  idx[4];
    logic [23:0] val[4];
    idx = '{CFG_CELL_SIZE, CFG_WALL_HALF, CFG_EDGE_EPS, CFG_SPARE};
    val = '{cs, wh, ep, 24'($urandom)};
    for (int i = 0; i < 4; i++) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= idx[i];
      cfg_data_i  <= val[i];
      do @(posedge clk_i); while (!cfg_ready_o);
      cfg_count++;
    end
    cfg_valid_i <= 1'b0;
    cur_cs = cs;
    @(posedge clk_i);
  endtask

  task automatic maybe_idle();
    if (allow_idle && $urandom_range(0, 5) == 0) begin
      start_i <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
  endtask

  // Place the centre near a random cell so neighbouring walls are in reach.
  task automatic random_query();
    longint signed cs, px, pz;
    logic [23:0] rad;
    cs = (cur_cs == 0) ? 1 : cur_cs;
    if ($urandom_range(0, 9) == 0) begin
      query($urandom, $urandom, 24'($urandom));
      return;
    end
    px = longint'($urandom_range(0, 17)) * cs - cs + longint'($urandom_range(0, 2 * cs));
    pz = longint'($urandom_range(0, 17)) * cs - cs + longint'($urandom_range(0, 2 * cs));
    if (px > 64'sd2147483647) px = 64'sd2147483647;
    if (pz > 64'sd2147483647) pz = 64'sd2147483647;
    case ($urandom_range(0, 3))
      0: rad = 24'($urandom_range(0, 16));
      1: rad = 24'($urandom);
      default: rad = 24'($urandom_range(0, (cs > 24'hffffff) ? 24'hffffff : cs));
    endcase
    query(px[31:0], pz[31:0], rad);
  endtask

  initial begin
    logic [23:0] cs_set[6], wh_set[6], ep_set[6];
    int phase_len, sent;
    // reset values first, then small and extreme settings, zero cell size among them
    cs_set = '{24'd262144, 24'd1, 24'hffffff, 24'd0, 24'd65536, 24'd1000};
    wh_set = '{24'd6554, 24'd0, 24'h7fffff, 24'hffffff, 24'd200, 24'd3};
    ep_set = '{24'd1, 24'd0, 24'hffff, 24'd7, 24'd65535, 24'd0};
    load_count = 0;
    query_count = 0;
    cfg_count = 0;
    allow_idle = 1'b1;
    cur_cs = 24'd262144;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty map, corner cells, every wall kind, inside-box and grid edges.
    query(32'sd0, 32'sd0, 24'hffffff);
    load_cell(4'd0, 4'd0, 4'hf);
    load_cell(4'd15, 4'd15, 4'hf);
    load_cell(4'd1, 4'd1, 4'b0001);
    load_cell(4'd2, 4'd1, 4'b0010);
    load_cell(4'd1, 4'd2, 4'b0100);
    load_cell(4'd2, 4'd2, 4'b1000);
    query(32'sd389939, 32'sd262144, 24'd10);
    query(32'sd0, 32'sd0, 24'd0);
    query(32'sd0, 32'sd0, 24'hffffff);
    query(-32'sd100000, -32'sd100000, 24'd300000);
    query(32'sd3932160, 32'sd3932160, 24'hffffff);
    query(32'sh7fffffff, 32'sh7fffffff, 24'hffffff);
    query(32'sh80000000, 32'sh80000000, 24'hffffff);
    query(32'sd393216, 32'sd393216, 24'd200000);
    query(32'sd524288, 32'sd393216, 24'd131072);
    load_cell(4'd1, 4'd1, 4'd0);
    query(32'sd262144, 32'sd262144, 24'd262144);
    drain();

    phase_len = (ITEMS - 20) / 6;
    sent = 20;
    for (int p = 0; p < 6; p++) begin
      if (p > 0) begin
        drain();
        set_config(cs_set[p], wh_set[p], ep_set[p]);
      end
      for (int i = 0; i < phase_len; i++) begin
        if (ITEMS - sent < CALM_ITEMS) allow_idle = 1'b0;
        maybe_idle();
        if ($urandom_range(0, 2) == 0) load_cell(4'($urandom), 4'($urandom), 4'($urandom));
        else random_query();
        sent++;
      end
    end

    // End: wait for every result, then let the pipeline settle.
    start_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    $display("Covered %0d loads, %0d queries (%0d colliding), %0d register writes",
             load_count, query_count, hits, cfg_count);
    $display("across six register settings including zero and full-scale cell size.");
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d failures", fail_count);
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
